/* hdl/greedy_activity_selector_macros.svh */
// assertion macros shared by the greedy activity selector checker
// depends on clk_i and rst_ni being visible at the point of use
`ifndef GREEDY_ACTIVITY_SELECTOR_MACROS_SVH
`define GREEDY_ACTIVITY_SELECTOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define GAS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define GAS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/gas_pkg.sv */
// shared types and constants of the greedy activity selector
// no dependencies
package gas_pkg;

  // width of the running selection count on the result stream
  localparam int unsigned COUNT_W = 7;

  // controller states, one-hot
  typedef enum logic [4:0] {
    ST_LOAD   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_DRAIN  = 5'b00100,
    ST_DECIDE = 5'b01000,
    ST_OUT    = 5'b10000
  } gas_state_e;

endpackage

/* hdl/gas_ram.sv */
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module gas_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* hdl/greedy_activity_selector.sv */
// greedy activity selector: while loading, takes one activity per cycle into a ram
// in arrival order. at batch end each selection is one pass over the n stored entries,
// looking for the earliest-finish entry after the last taken one that starts in time.
// the next pass starts only once the pending result is taken, so output stalls hold it up.
// reset (async, active low) empties the batch; the ram needs no clearing.
// depends on gas_pkg and gas_ram
module greedy_activity_selector
  import gas_pkg::*;
#(
  parameter int unsigned MAX_ACTIVITIES = 64,
  parameter int unsigned TIME_BITS      = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // start_time, finish_time
  input  logic [((2*TIME_BITS+7)/8)*8-1:0] s_axis_tdata_i,
  input  logic s_axis_tlast_i,
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  // chosen_start, chosen_finish, chosen_count
  output logic [((2*TIME_BITS+COUNT_W+7)/8)*8-1:0] m_axis_tdata_o,
  // overflow
  output logic [0:0] m_axis_tuser_o,
  output logic m_axis_tlast_o
);

  localparam int unsigned AW    = (MAX_ACTIVITIES > 1) ? $clog2(MAX_ACTIVITIES) : 1;
  localparam int unsigned CW    = $clog2(MAX_ACTIVITIES + 1);
  localparam int unsigned OUT_W = ((2*TIME_BITS+COUNT_W+7)/8)*8;

  gas_state_e state_q, state_d;

  logic [CW-1:0]        cnt_q;
  logic                 dropped_q;
  logic [AW-1:0]        ptr_q;
  logic                 rd_valid_q;
  logic [AW-1:0]        rd_idx_q;
  logic                 cand_found_q;
  logic [AW-1:0]        cand_idx_q;
  logic [TIME_BITS-1:0] cand_start_q, cand_finish_q;
  logic                 have_held_q;
  logic [AW-1:0]        held_idx_q;
  logic [TIME_BITS-1:0] held_start_q, held_finish_q;
  logic [COUNT_W-1:0]   held_cnt_q;
  logic                 out_valid_q, out_last_q, out_ovf_q;
  logic [TIME_BITS-1:0] out_start_q, out_finish_q;
  logic [COUNT_W-1:0]   out_cnt_q;

  logic                   in_acc, out_acc, room, we, re, last_issue;
  logic [2*TIME_BITS-1:0] rdata;
  logic [TIME_BITS-1:0]   rd_start, rd_finish;
  logic                   after_held, fits, better;

  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc = out_valid_q && m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_LOAD);
  assign room = (cnt_q < CW'(MAX_ACTIVITIES));
  assign we = in_acc && room;
  assign re = (state_q == ST_SCAN);
  assign last_issue = ((CW'(ptr_q) + CW'(1)) == cnt_q);

  gas_ram #(
    .WIDTH(2*TIME_BITS),
    .DEPTH(MAX_ACTIVITIES),
    .AW   (AW)
  ) u_slots (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(cnt_q[AW-1:0]),
    .wdata_i(s_axis_tdata_i[2*TIME_BITS-1:0]),
    .re_i   (re),
    .raddr_i(ptr_q),
    .rdata_o(rdata)
  );

  assign rd_start  = rdata[TIME_BITS-1:0];
  assign rd_finish = rdata[2*TIME_BITS-1:TIME_BITS];

  // entry qualifies if none is held yet, or it sorts after the held one and starts at or after its finish
  assign after_held = (rd_finish > held_finish_q) ||
                      ((rd_finish == held_finish_q) && (rd_idx_q > held_idx_q));
  assign fits = !have_held_q || (after_held && (rd_start >= held_finish_q));
  // scan runs in index order, so a strict finish compare keeps ties stable
  assign better = !cand_found_q || (rd_finish < cand_finish_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: begin
        if (in_acc && s_axis_tlast_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (last_issue) state_d = ST_DRAIN;
      end
      ST_DRAIN: state_d = ST_DECIDE;
      ST_DECIDE: begin
        if (cand_found_q && !have_held_q) state_d = ST_SCAN;
        else state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_acc) state_d = out_last_q ? ST_LOAD : ST_SCAN;
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_LOAD;
      cnt_q        <= '0;
      dropped_q    <= 1'b0;
      ptr_q        <= '0;
      rd_valid_q   <= 1'b0;
      cand_found_q <= 1'b0;
      have_held_q  <= 1'b0;
      held_cnt_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_valid_q <= re;
      // loading
      if (in_acc) begin
        if (room) cnt_q <= cnt_q + CW'(1);
        else dropped_q <= 1'b1;
        if (s_axis_tlast_i) begin
          ptr_q       <= '0;
          have_held_q <= 1'b0;
          held_cnt_q  <= '0;
        end
      end
      // read issue
      if (re) begin
        ptr_q <= last_issue ? '0 : ptr_q + AW'(1);
        if (ptr_q == '0) cand_found_q <= 1'b0;
      end
      // candidate search on returned data
      if (rd_valid_q && fits && better) cand_found_q <= 1'b1;
      // decision at end of pass
      if (state_q == ST_DECIDE) begin
        if (cand_found_q) begin
          have_held_q <= 1'b1;
          held_cnt_q  <= held_cnt_q + COUNT_W'(1);
        end
        if (have_held_q) out_valid_q <= 1'b1;
      end
      // result handoff ends the batch when it was the last one
      if (out_acc) begin
        out_valid_q <= 1'b0;
        if (out_last_q) begin
          cnt_q     <= '0;
          dropped_q <= 1'b0;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (re) rd_idx_q <= ptr_q;
    if (rd_valid_q && fits && better) begin
      cand_idx_q    <= rd_idx_q;
      cand_start_q  <= rd_start;
      cand_finish_q <= rd_finish;
    end
    if (state_q == ST_DECIDE) begin
      out_start_q  <= held_start_q;
      out_finish_q <= held_finish_q;
      out_cnt_q    <= held_cnt_q;
      out_ovf_q    <= dropped_q;
      out_last_q   <= !cand_found_q;
      if (cand_found_q) begin
        held_idx_q    <= cand_idx_q;
        held_start_q  <= cand_start_q;
        held_finish_q <= cand_finish_q;
      end
    end
  end

  // output stream
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_W'({out_cnt_q, out_finish_q, out_start_q});
  assign m_axis_tuser_o  = out_ovf_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

/* hdl/gas_checker.sv */
// port-level checker for the greedy activity selector, bound to the top level
// depends on gas_pkg and greedy_activity_selector_macros.svh
`include "greedy_activity_selector_macros.svh"
module gas_checker
  import gas_pkg::*;
#(
  parameter int unsigned TIME_BITS = 16
) (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tvalid_i,
  input logic s_axis_tready_o,
  input logic s_axis_tlast_i,
  input logic m_axis_tvalid_o,
  input logic m_axis_tready_i,
  input logic m_axis_tlast_o,
  input logic [((2*TIME_BITS+COUNT_W+7)/8)*8-1:0] m_axis_tdata_o
);

  // result request holds until taken
  `GAS_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o), "result request dropped or changed while stalled")

  // no input is taken while a result is pending
  `GAS_ASSERT_NOW(a_no_load_while_out, m_axis_tvalid_o, !s_axis_tready_o, "input accepted during result phase")

  // closing request stops the input side
  `GAS_ASSERT_NEXT(a_close_batch, s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i, !s_axis_tready_o, "input still ready after batch end")

  // last result hands back to loading with nothing pending
  `GAS_ASSERT_NEXT(a_last_done, m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o, !m_axis_tvalid_o && s_axis_tready_o, "block not idle after last result")

endmodule

bind greedy_activity_selector gas_checker #(.TIME_BITS(TIME_BITS)) u_gas_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o),
  .s_axis_tlast_i (s_axis_tlast_i),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tlast_o (m_axis_tlast_o),
  .m_axis_tdata_o (m_axis_tdata_o)
);
